/* design/pbgt_pkg.sv */
// Shared types and constants for the page/block generation tracker.
// Holds default geometry, opcodes, register indexes, control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pbgt_pkg;

  localparam int PAGE_SHIFT_DEF  = 12;
  localparam int BLOCK_SHIFT_DEF = 16;
  localparam int MAX_PAGES_DEF   = 65536;
  localparam int NUM_SPACES_DEF  = 2;

  localparam int OP_W      = 2;
  localparam int SP_W      = 2;
  localparam int CFG_W     = 17;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int S_TDATA_W = 104;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 64;
  localparam int CNT_W     = 32;
  localparam int EPOCH_W   = 64;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE     = 2'd0,
    OP_RD_PAGE  = 2'd1,
    OP_RD_BLOCK = 2'd2,
    OP_RD_EPOCH = 2'd3
  } opcode_t;

  // register index, taken from paddr[2]
  localparam logic REG_LOCAL_PAGES = 1'b0;
  localparam logic REG_MAIN_PAGES  = 1'b1;

  // spaces that have a size register
  localparam logic [SP_W-1:0] REG_SPACES = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] local_space_pages;
    logic [CFG_W-1:0] main_space_pages;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic geom;
    logic check;
    logic range;
    logic clr;
    logic pg_rd;
    logic pg_wr;
    logic bk_rd;
    logic bk_wr;
    logic epoch_inc;
    logic rd_mem;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_write;
    logic wr_ok;
    logic page_last;
    logic block_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* design/page_block_generation_tracker_unit.sv */
// Read item: geometry, check and one memory read follow acceptance; the next item is
// taken once m_axis_tready frees the result register for the result. Write note: geometry,
// check, range, then a read and a write per page and per block touched, the epoch bump;
// an ignored note ends at range. Counters live in the single-port page or block memory.
// Reset: synchronous, active high; epochs and size registers clear at once, then a sweep of
// max(page, block depth) addresses (131072 by default) zeroes both memories, tready low.
`timescale 1ns / 1ps
`default_nettype none
module page_block_generation_tracker_unit #(
  parameter int PAGE_SHIFT  = pbgt_pkg::PAGE_SHIFT_DEF,
  parameter int BLOCK_SHIFT = pbgt_pkg::BLOCK_SHIFT_DEF,
  parameter int MAX_PAGES   = pbgt_pkg::MAX_PAGES_DEF,
  parameter int NUM_SPACES  = pbgt_pkg::NUM_SPACES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // APB config: reg 0 local_space_pages at 0x0, reg 1 main_space_pages at 0x4
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pbgt_pkg::APB_AW-1:0]      paddr,
  input  wire logic [pbgt_pkg::APB_DW-1:0]      pwdata,
  output logic      [pbgt_pkg::APB_DW-1:0]      prdata,
  output logic                                  pready,
  // input items
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [1:0] space_sel, [33:2] byte_offset, [65:34] byte_count,
  // [97:66] entry_index, [103:98] zero
  input  wire logic [pbgt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  wire logic [pbgt_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // result items, one per read item
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [63:0] read_value
  output logic      [pbgt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  pbgt_pkg::cfg_t    cfg;
  pbgt_pkg::cmd_t    cmd;
  pbgt_pkg::status_t status;

  // Size registers. The counters keep their values across a size change.
  pbgt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: clear sweep, then per item geometry, range check, and either
  // the page/block walk plus epoch bump (none for an ignored note), or one memory read and the result.
  pbgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath: the result register decouples the output side, so a new item
  // is taken while an earlier result still waits for m_axis_tready.
  pbgt_dp #(
    .PAGE_SHIFT  (PAGE_SHIFT),
    .BLOCK_SHIFT (BLOCK_SHIFT),
    .MAX_PAGES   (MAX_PAGES),
    .NUM_SPACES  (NUM_SPACES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

/* design/pbgt_cfg.sv */
// APB register file: space size registers.
// Depends on pbgt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbgt_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pbgt_pkg::APB_AW-1:0]   paddr,
  input  wire logic [pbgt_pkg::APB_DW-1:0]   pwdata,
  output logic      [pbgt_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output pbgt_pkg::cfg_t                     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        pbgt_pkg::REG_LOCAL_PAGES: cfg.local_space_pages <= pwdata[pbgt_pkg::CFG_W-1:0];
        pbgt_pkg::REG_MAIN_PAGES:  cfg.main_space_pages  <= pwdata[pbgt_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pbgt_pkg::REG_LOCAL_PAGES:
        prdata = pbgt_pkg::APB_DW'(cfg.local_space_pages);
      pbgt_pkg::REG_MAIN_PAGES:
        prdata = pbgt_pkg::APB_DW'(cfg.main_space_pages);
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* design/pbgt_ctrl.sv */
// Sequencer for the tracker: clear sweep, decode, counter walk, result.
// Depends on pbgt_pkg; drives the datapath through cmd_t / status_t.
`timescale 1ns / 1ps
`default_nettype none
module pbgt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output pbgt_pkg::cmd_t     cmd,
  input  wire pbgt_pkg::status_t status
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_GEOM   = 12'b0000_0000_0100,
    S_CHECK  = 12'b0000_0000_1000,
    S_RANGE  = 12'b0000_0001_0000,
    S_PG_RD  = 12'b0000_0010_0000,
    S_PG_WR  = 12'b0000_0100_0000,
    S_BK_RD  = 12'b0000_1000_0000,
    S_BK_WR  = 12'b0001_0000_0000,
    S_EPOCH  = 12'b0010_0000_0000,
    S_RD_MEM = 12'b0100_0000_0000,
    S_RESULT = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GEOM;
        end
      end
      S_GEOM: begin
        cmd.geom   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.is_write ? S_RANGE : S_RD_MEM;
      end
      S_RANGE: begin
        if (status.wr_ok) begin
          cmd.range  = 1'b1;
          state_next = S_PG_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PG_RD: begin
        cmd.pg_rd  = 1'b1;
        state_next = S_PG_WR;
      end
      S_PG_WR: begin
        cmd.pg_wr  = 1'b1;
        state_next = status.page_last ? S_BK_RD : S_PG_RD;
      end
      S_BK_RD: begin
        cmd.bk_rd  = 1'b1;
        state_next = S_BK_WR;
      end
      S_BK_WR: begin
        cmd.bk_wr  = 1'b1;
        state_next = status.block_last ? S_EPOCH : S_BK_RD;
      end
      S_EPOCH: begin
        cmd.epoch_inc = 1'b1;
        state_next    = S_IDLE;
      end
      S_RD_MEM: begin
        cmd.rd_mem = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/pbgt_dp.sv */
// Tracker datapath: item registers, space geometry, range clip, walk
// counters, page and block counter memories, epochs, output register.
// Depends on pbgt_pkg; sequenced by pbgt_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module pbgt_dp #(
  parameter int PAGE_SHIFT  = pbgt_pkg::PAGE_SHIFT_DEF,
  parameter int BLOCK_SHIFT = pbgt_pkg::BLOCK_SHIFT_DEF,
  parameter int MAX_PAGES   = pbgt_pkg::MAX_PAGES_DEF,
  parameter int NUM_SPACES  = pbgt_pkg::NUM_SPACES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pbgt_pkg::cmd_t                   cmd,
  output pbgt_pkg::status_t                     status,
  input  wire pbgt_pkg::cfg_t                   cfg,
  input  wire logic [pbgt_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic [pbgt_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [pbgt_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam longint MAX_BYTES   = longint'(MAX_PAGES) << PAGE_SHIFT;
  localparam longint BLOCK_ROUND = (longint'(1) << BLOCK_SHIFT) - 1;
  localparam longint MAX_BLOCKS  = (MAX_BYTES + BLOCK_ROUND) >> BLOCK_SHIFT;
  localparam longint PAGE_DEPTH  = longint'(NUM_SPACES) * longint'(MAX_PAGES);
  localparam longint BLOCK_DEPTH = longint'(NUM_SPACES) * MAX_BLOCKS;
  localparam longint CLR_DEPTH   = (PAGE_DEPTH > BLOCK_DEPTH) ? PAGE_DEPTH : BLOCK_DEPTH;

  localparam int PAGE_CNT_W = $clog2(MAX_PAGES + 1);
  localparam int BLK_CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PIDX_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int BIDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PADDR_W    = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;
  localparam int BADDR_W    = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int CLR_W      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int SIDX_W     = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
  localparam int CMP_W      = (pbgt_pkg::CFG_W > PAGE_CNT_W) ? pbgt_pkg::CFG_W : PAGE_CNT_W;
  localparam int BYTES_W    = PAGE_CNT_W + PAGE_SHIFT;
  localparam int BX_W       = (BYTES_W > 33) ? BYTES_W : 33;
  localparam int SUM_W      = ((BYTES_W > BLOCK_SHIFT) ? BYTES_W : BLOCK_SHIFT) + 1;
  localparam int CNT_W      = pbgt_pkg::CNT_W;

  // item registers
  pbgt_pkg::opcode_t         op_q;
  logic [pbgt_pkg::SP_W-1:0] sp_q;
  logic [31:0]               off_q;
  logic [31:0]               len_q;
  logic [31:0]               idx_q;

  // geometry of the addressed space
  logic                  space_ok_q;
  logic [PAGE_CNT_W-1:0] npages_q;
  logic [BLK_CNT_W-1:0]  nblocks_q;
  logic [31:0]           nbytes_q;
  logic [PADDR_W-1:0]    page_base_q;
  logic [BADDR_W-1:0]    block_base_q;

  // range check
  logic        wr_ok_q;
  logic        rd_ok_q;
  logic [32:0] end_raw_q;

  // walk counters
  logic [PIDX_W-1:0] page_cur;
  logic [PIDX_W-1:0] page_end;
  logic [BIDX_W-1:0] block_cur;
  logic [BIDX_W-1:0] block_end;

  logic [CLR_W-1:0] clr_cnt;

  logic [CNT_W-1:0] pg_mem [PAGE_DEPTH];
  logic [CNT_W-1:0] bk_mem [BLOCK_DEPTH];
  logic [CNT_W-1:0] pg_rdata;
  logic [CNT_W-1:0] bk_rdata;

  logic [pbgt_pkg::EPOCH_W-1:0] epochs [NUM_SPACES];
  logic [SIDX_W-1:0]            sidx;

  // geometry logic
  logic [pbgt_pkg::CFG_W-1:0] sel_raw;
  logic [PAGE_CNT_W-1:0]      pages_c;
  logic [BYTES_W-1:0]         bytes_c;
  logic [BX_W-1:0]            bytes_x;
  logic [SUM_W-1:0]           blk_sum;

  always_comb begin
    sel_raw = (sp_q == '0) ? cfg.local_space_pages : cfg.main_space_pages;
    pages_c = (CMP_W'(sel_raw) > CMP_W'(MAX_PAGES)) ? PAGE_CNT_W'(MAX_PAGES)
                                                    : PAGE_CNT_W'(sel_raw);
    bytes_c = BYTES_W'(pages_c) << PAGE_SHIFT;
    bytes_x = BX_W'(bytes_c);
    blk_sum = (SUM_W'(bytes_c) + SUM_W'(BLOCK_ROUND)) >> BLOCK_SHIFT;
  end

  // check logic
  logic [32:0] end_raw_c;
  logic        rd_ok_c;

  always_comb begin
    end_raw_c = {1'b0, off_q} + {1'b0, len_q} - 33'd1;
    case (op_q)
      pbgt_pkg::OP_RD_PAGE:  rd_ok_c = idx_q < 32'(npages_q);
      pbgt_pkg::OP_RD_BLOCK: rd_ok_c = idx_q < 32'(nblocks_q);
      pbgt_pkg::OP_RD_EPOCH: rd_ok_c = 1'b1;
      default:               rd_ok_c = 1'b0;
    endcase
  end

  // last byte of the clipped range
  logic [31:0] last_c;
  assign last_c = (end_raw_q < {1'b0, nbytes_q}) ? end_raw_q[31:0] : nbytes_q - 32'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= pbgt_pkg::opcode_t'(s_tuser[pbgt_pkg::OP_W-1:0]);
      sp_q  <= s_tdata[1:0];
      off_q <= s_tdata[33:2];
      len_q <= s_tdata[65:34];
      idx_q <= s_tdata[97:66];
    end
    if (cmd.geom) begin
      space_ok_q   <= ({1'b0, sp_q} < 3'(NUM_SPACES)) && (sp_q < pbgt_pkg::REG_SPACES)
                      && (pages_c != '0);
      npages_q     <= pages_c;
      nblocks_q    <= BLK_CNT_W'(blk_sum);
      nbytes_q     <= (|bytes_x[BX_W-1:32]) ? 32'hFFFF_FFFF : bytes_x[31:0];
      page_base_q  <= PADDR_W'(PADDR_W'(sp_q) * PADDR_W'(MAX_PAGES));
      block_base_q <= BADDR_W'(BADDR_W'(sp_q) * BADDR_W'(MAX_BLOCKS));
    end
    if (cmd.check) begin
      end_raw_q <= end_raw_c;
      wr_ok_q   <= space_ok_q && (len_q != '0) && (off_q < nbytes_q);
      rd_ok_q   <= space_ok_q && rd_ok_c;
    end
    if (cmd.range) begin
      page_cur  <= PIDX_W'(off_q >> PAGE_SHIFT);
      page_end  <= PIDX_W'(last_c >> PAGE_SHIFT);
      block_cur <= BIDX_W'(off_q >> BLOCK_SHIFT);
      block_end <= BIDX_W'(last_c >> BLOCK_SHIFT);
    end else begin
      if (cmd.pg_wr) page_cur <= page_cur + 1'b1;
      if (cmd.bk_wr) block_cur <= block_cur + 1'b1;
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // memory ports
  logic               pg_we;
  logic               bk_we;
  logic               pg_re;
  logic               bk_re;
  logic [PADDR_W-1:0] pg_addr;
  logic [BADDR_W-1:0] bk_addr;
  logic [CNT_W-1:0]   pg_wdata;
  logic [CNT_W-1:0]   bk_wdata;

  always_comb begin
    pg_we    = (cmd.clr && ({1'b0, clr_cnt} < (CLR_W + 1)'(PAGE_DEPTH))) || cmd.pg_wr;
    bk_we    = (cmd.clr && ({1'b0, clr_cnt} < (CLR_W + 1)'(BLOCK_DEPTH))) || cmd.bk_wr;
    pg_re    = cmd.pg_rd || cmd.rd_mem;
    bk_re    = cmd.bk_rd || cmd.rd_mem;
    pg_wdata = cmd.clr ? '0 : pg_rdata + 1'b1;
    bk_wdata = cmd.clr ? '0 : bk_rdata + 1'b1;
    if (cmd.clr) begin
      pg_addr = PADDR_W'(clr_cnt);
      bk_addr = BADDR_W'(clr_cnt);
    end else if (cmd.rd_mem) begin
      pg_addr = page_base_q + PADDR_W'(idx_q);
      bk_addr = block_base_q + BADDR_W'(idx_q);
    end else begin
      pg_addr = page_base_q + PADDR_W'(page_cur);
      bk_addr = block_base_q + BADDR_W'(block_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (pg_we) pg_mem[pg_addr] <= pg_wdata;
    if (pg_re) pg_rdata <= pg_mem[pg_addr];
  end

  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[bk_addr] <= bk_wdata;
    if (bk_re) bk_rdata <= bk_mem[bk_addr];
  end

  // epochs
  assign sidx = SIDX_W'(sp_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SPACES; i++) epochs[i] <= '0;
    end else if (cmd.epoch_inc) begin
      epochs[sidx] <= epochs[sidx] + 1'b1;
    end
  end

  // result register
  logic [pbgt_pkg::M_TDATA_W-1:0] result_c;

  always_comb begin
    case (op_q)
      pbgt_pkg::OP_RD_PAGE:  result_c = pbgt_pkg::M_TDATA_W'(pg_rdata);
      pbgt_pkg::OP_RD_BLOCK: result_c = pbgt_pkg::M_TDATA_W'(bk_rdata);
      pbgt_pkg::OP_RD_EPOCH: result_c = epochs[sidx];
      default:               result_c = '0;
    endcase
    if (!rd_ok_q) result_c = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= result_c;
  end

  always_comb begin
    status.clear_done = (clr_cnt == CLR_W'(CLR_DEPTH - 1));
    status.is_write   = (op_q == pbgt_pkg::OP_NOTE);
    status.wr_ok      = wr_ok_q;
    status.page_last  = (page_cur == page_end);
    status.block_last = (block_cur == block_end);
    status.out_free   = !m_tvalid || m_tready;
  end

endmodule
`default_nettype wire
